/* sv/srmd_pkg.sv */
// ----------------------------------------------------------------------------
// srmd_pkg: shared types and constants for the sensor reply decoder
// Request and result structs, status and function codes, stage structs and
// width helpers that follow from the number of fraction bits.
// ----------------------------------------------------------------------------
package srmd_pkg;

    localparam int FRAC_BITS_DEF = 18;
    localparam int VALUE_W       = 40;
    localparam int SIG_W         = 12;           // hidden one, 3 + 8 mantissa bits
    localparam int EXP_MAX       = 15;
    localparam int MAG0_W        = SIG_W + EXP_MAX;
    localparam int FRAC_REF      = 18;           // fraction bits with no extra shift
    localparam int RES_SCALE     = 1000;
    localparam int TEMP_OFFSET   = 32;

    localparam logic [7:0] BROADCAST_ID = 8'hFF;
    localparam logic [1:0] LAST_POS     = 2'd3;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ADDR = 2'd1,
        ST_CSUM = 2'd2,
        ST_ZERO = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FN_RES  = 2'd0,
        FN_RAW  = 2'd1,
        FN_VOLT = 2'd2,
        FN_TEMP = 2'd3
    } func_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
        logic [7:0] sent_id;
        logic [1:0] func;
    } byte_req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [1:0]                status;
        logic                      error_flag;
    } result_t;

    typedef struct packed {
        status_t status;
        logic    error_flag;
        func_t   func;
    } meta_t;

    typedef struct packed {
        meta_t      meta;
        logic [7:0] hi;
        logic [7:0] lo;
    } check_t;

    function automatic int shl_bits(int frac);
        return (frac >= FRAC_REF) ? frac - FRAC_REF : 0;
    endfunction

    function automatic int shr_bits(int frac);
        return (frac < FRAC_REF) ? FRAC_REF - frac : 0;
    endfunction

    function automatic int mag_width(int frac);
        return MAG0_W + shl_bits(frac);
    endfunction

    // magnitude of (v - 32) times five
    function automatic int x_width(int frac);
        return mag_width(frac) + 4;
    endfunction

    // signed product v * 1000, at least one bit above the result width
    function automatic int sat_width(int frac);
        return (mag_width(frac) + 11 > VALUE_W + 1) ? mag_width(frac) + 11 : VALUE_W + 1;
    endfunction

endpackage

/* sv/srmd_frame.sv */
// ----------------------------------------------------------------------------
// srmd_frame: byte framing and reply checks
// Collects the first three reply bytes, checks the fourth against address,
// checksum and zero value, keeps the sticky error flag and loads stage one.
// ----------------------------------------------------------------------------
module srmd_frame (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  srmd_pkg::byte_req_t byte_data,
    output logic               s1_valid,
    input  logic               s2_ready,
    output srmd_pkg::check_t   s1_data
);
    import srmd_pkg::*;

    logic [1:0] pos_reg, pos_next;
    logic [7:0] bytes_reg [3];
    logic       err_reg, err_next;
    logic       s1_valid_reg, s1_valid_next;
    check_t     s1_data_reg;

    logic [1:0] pos_eff;
    logic       last_byte;
    logic       s1_ready;
    logic       accept;
    logic       load;
    logic [7:0] csum;
    status_t    status;
    logic       err_chk;
    func_t      func;

    always_comb
    begin
        pos_eff   = byte_data.frame_start ? 2'd0 : pos_reg;
        last_byte = (pos_eff == LAST_POS);
        s1_ready  = !s1_valid_reg || s2_ready;
        accept    = byte_valid && s1_ready;
        load      = accept && last_byte;
        func      = func_t'(byte_data.func);
        csum      = bytes_reg[0] ^ bytes_reg[1] ^ bytes_reg[2];
        err_chk   = err_reg;
        priority if (bytes_reg[0] != byte_data.sent_id)
        begin
            status = ST_ADDR;
            // a broadcast request leaves the flag alone for voltage and temperature
            if (func == FN_RES || func == FN_RAW || byte_data.sent_id != BROADCAST_ID)
            begin
                err_chk = 1'b1;
            end
        end
        else if (csum != byte_data.rx_byte)
        begin
            status = ST_CSUM;
        end
        else if (bytes_reg[1] == 8'd0 && bytes_reg[2] == 8'd0)
        begin
            status  = ST_ZERO;
            err_chk = 1'b1;
        end
        else
        begin
            status  = ST_OK;
            err_chk = 1'b0;
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            pos_next = last_byte ? 2'd0 : pos_eff + 2'd1;
        end
        err_next      = load ? err_chk : err_reg;
        s1_valid_next = load ? 1'b1 : (s1_ready ? 1'b0 : s1_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= 2'd0;
            err_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            err_reg      <= err_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !last_byte)
        begin
            bytes_reg[pos_eff] <= byte_data.rx_byte;
        end
        if (load)
        begin
            s1_data_reg.meta.status     <= status;
            s1_data_reg.meta.error_flag <= err_chk;
            s1_data_reg.meta.func       <= func;
            s1_data_reg.hi              <= bytes_reg[1];
            s1_data_reg.lo              <= bytes_reg[2];
        end
    end

    assign byte_stall = !s1_ready;
    assign s1_valid   = s1_valid_reg;
    assign s1_data    = s1_data_reg;

endmodule

/* sv/srmd_decode.sv */
// ----------------------------------------------------------------------------
// srmd_decode: minifloat to fixed point, first scaling step
// Expands the minifloat, forms v * 1000 for resistance and |v - 32| * 5 with
// its sign for temperature, and registers them for the divide stages.
// ----------------------------------------------------------------------------
module srmd_decode #(
    parameter int FRAC_BITS = srmd_pkg::FRAC_BITS_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         s1_valid,
    output logic                                         s2_ready,
    input  srmd_pkg::check_t                             s1_data,
    output logic                                         s2_valid,
    input  logic                                         s3_ready,
    output srmd_pkg::meta_t                              s2_meta,
    output logic signed [srmd_pkg::sat_width(FRAC_BITS)-1:0] s2_wide,
    output logic [srmd_pkg::x_width(FRAC_BITS)-1:0]      s2_x,
    output logic                                         s2_neg
);
    import srmd_pkg::*;

    localparam int SHL   = shl_bits(FRAC_BITS);
    localparam int SHR   = shr_bits(FRAC_BITS);
    localparam int MAG_W = mag_width(FRAC_BITS);
    localparam int V_W   = MAG_W + 1;
    localparam int T_SW  = V_W + 1;
    localparam int X_W   = x_width(FRAC_BITS);
    localparam int SAT_W = sat_width(FRAC_BITS);

    localparam logic signed [T_SW-1:0]  TEMP_OFF = T_SW'(longint'(TEMP_OFFSET) << FRAC_BITS);
    localparam logic signed [SAT_W-1:0] RES_K    = SAT_W'(RES_SCALE);

    logic                     valid_reg, valid_next;
    meta_t                    meta_reg;
    logic signed [SAT_W-1:0]  wide_reg, wide_next;
    logic [X_W-1:0]           x_reg, x_next;
    logic                     neg_reg, neg_next;

    logic                     load;
    logic [SIG_W-1:0]         sig;
    logic [MAG0_W-1:0]        mag0;
    logic [MAG_W-1:0]         mag;
    logic signed [V_W-1:0]    v;
    logic signed [SAT_W-1:0]  v_ext;
    logic signed [T_SW-1:0]   t;
    logic signed [T_SW-1:0]   t_abs;
    logic [T_SW-2:0]          a;

    always_comb
    begin
        sig   = {1'b1, s1_data.hi[2:0], s1_data.lo};
        mag0  = MAG0_W'(sig) << s1_data.hi[6:3];
        // one of the two shifts is zero
        mag   = (MAG_W'(mag0) << SHL) >> SHR;
        v     = s1_data.hi[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        v_ext = SAT_W'(v);
        wide_next = (s1_data.meta.func == FN_RES) ? v_ext * RES_K : v_ext;
        t        = T_SW'(v) - TEMP_OFF;
        neg_next = t[T_SW-1];
        t_abs    = neg_next ? -t : t;
        a        = t_abs[T_SW-2:0];
        x_next   = (X_W'(a) << 2) + X_W'(a);
    end

    always_comb
    begin
        s2_ready   = !valid_reg || s3_ready;
        load       = s1_valid && s2_ready;
        valid_next = load ? 1'b1 : (s2_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            meta_reg <= s1_data.meta;
            wide_reg <= wide_next;
            x_reg    <= x_next;
            neg_reg  <= neg_next;
        end
    end

    assign s2_valid = valid_reg;
    assign s2_meta  = meta_reg;
    assign s2_wide  = wide_reg;
    assign s2_x     = x_reg;
    assign s2_neg   = neg_reg;

endmodule

/* sv/srmd_scale.sv */
// ----------------------------------------------------------------------------
// srmd_scale: divide by nine, saturation and result register
// Divides the temperature term by nine through a split reciprocal multiply,
// clamps the other path to 40 bits and holds the finished result.
// ----------------------------------------------------------------------------
module srmd_scale #(
    parameter int FRAC_BITS = srmd_pkg::FRAC_BITS_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         s2_valid,
    output logic                                         s3_ready,
    input  srmd_pkg::meta_t                              s2_meta,
    input  logic signed [srmd_pkg::sat_width(FRAC_BITS)-1:0] s2_wide,
    input  logic [srmd_pkg::x_width(FRAC_BITS)-1:0]      s2_x,
    input  logic                                         s2_neg,
    output logic                                         result_valid,
    input  logic                                         result_stall,
    output srmd_pkg::result_t                            result_data
);
    import srmd_pkg::*;

    localparam int X_W   = x_width(FRAC_BITS);
    localparam int SAT_W = sat_width(FRAC_BITS);
    localparam int K     = X_W + 4;
    localparam int MW    = X_W + 1;
    localparam int XL    = X_W / 2;
    localparam int XH    = X_W - XL;
    localparam int PLO_W = XL + MW;
    localparam int PHI_W = XH + MW;
    localparam int SUM_W = X_W + MW;
    localparam int Q_W   = SUM_W - K;

    // ceil(2^K / 9): exact quotient for every X_W-bit dividend
    localparam logic [63:0]             RECIP_FULL = ((64'd1 << K) + 64'd8) / 64'd9;
    localparam logic [MW-1:0]           RECIP      = RECIP_FULL[MW-1:0];
    localparam logic signed [SAT_W-1:0] VAL_MAX_W  = SAT_W'({1'b0, {(VALUE_W-1){1'b1}}});
    localparam logic signed [SAT_W-1:0] VAL_MIN_W  = ~VAL_MAX_W;

    logic                      s3_valid_reg, s3_valid_next;
    meta_t                     s3_meta_reg;
    logic [PLO_W-1:0]          p_lo_reg, p_lo_next;
    logic [PHI_W-1:0]          p_hi_reg, p_hi_next;
    logic                      s3_neg_reg;
    logic signed [VALUE_W-1:0] sat_reg, sat_next;

    logic                      out_valid_reg, out_valid_next;
    result_t                   out_reg, out_next;

    logic                      out_ready;
    logic                      load3;
    logic                      load4;
    logic [SUM_W-1:0]          sum;
    logic [Q_W-1:0]            q;
    logic [VALUE_W-1:0]        q_ext;
    logic signed [VALUE_W-1:0] temp_val;

    always_comb
    begin
        p_lo_next = PLO_W'(s2_x[XL-1:0]) * PLO_W'(RECIP);
        p_hi_next = PHI_W'(s2_x[X_W-1:XL]) * PHI_W'(RECIP);
        priority if (s2_wide > VAL_MAX_W)
        begin
            sat_next = VAL_MAX_W[VALUE_W-1:0];
        end
        else if (s2_wide < VAL_MIN_W)
        begin
            sat_next = VAL_MIN_W[VALUE_W-1:0];
        end
        else
        begin
            sat_next = s2_wide[VALUE_W-1:0];
        end
    end

    always_comb
    begin
        sum      = (SUM_W'(p_hi_reg) << XL) + SUM_W'(p_lo_reg);
        q        = sum[SUM_W-1:K];
        q_ext    = VALUE_W'(q);
        // C division truncates toward zero: divide the magnitude, then sign
        temp_val = s3_neg_reg ? -q_ext : q_ext;
        out_next.status     = s3_meta_reg.status;
        out_next.error_flag = s3_meta_reg.error_flag;
        priority if (s3_meta_reg.status != ST_OK)
        begin
            out_next.value = '0;
        end
        else if (s3_meta_reg.func == FN_TEMP)
        begin
            out_next.value = temp_val;
        end
        else
        begin
            out_next.value = sat_reg;
        end
    end

    always_comb
    begin
        out_ready      = !out_valid_reg || !result_stall;
        s3_ready       = !s3_valid_reg || out_ready;
        load3          = s2_valid && s3_ready;
        load4          = s3_valid_reg && out_ready;
        s3_valid_next  = load3 ? 1'b1 : (s3_ready ? 1'b0 : s3_valid_reg);
        out_valid_next = load4 ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load3)
        begin
            s3_meta_reg <= s2_meta;
            p_lo_reg    <= p_lo_next;
            p_hi_reg    <= p_hi_next;
            s3_neg_reg  <= s2_neg;
            sat_reg     <= sat_next;
        end
        if (load4)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

endmodule

/* sv/sensor_reply_minifloat_decoder_top.sv */
// The checks register takes the fourth reply byte; decode, multiply and result registers follow.
// Four stages: checks, decode, reciprocal multiply, result; one byte per cycle unless stalled.
// The divide by nine is a split reciprocal multiply spread over the last two stages.
// Reset clears byte position, sticky error flag and all stage valids; reply bytes are not reset.
// ----------------------------------------------------------------------------
// sensor_reply_minifloat_decoder_top: battery sensor reply decoder
// Frames four-byte replies, checks them and converts the minifloat value to
// 40-bit signed fixed point scaled by the requested function.
// ----------------------------------------------------------------------------
module sensor_reply_minifloat_decoder_top #(
    parameter int FRAC_BITS = srmd_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  srmd_pkg::byte_req_t byte_data,
    output logic                result_valid,
    input  logic                result_stall,
    output srmd_pkg::result_t   result_data
);
    import srmd_pkg::*;

    localparam int X_W   = x_width(FRAC_BITS);
    localparam int SAT_W = sat_width(FRAC_BITS);

    logic                    s1_valid;
    logic                    s2_ready;
    check_t                  s1_data;
    logic                    s2_valid;
    logic                    s3_ready;
    meta_t                   s2_meta;
    logic signed [SAT_W-1:0] s2_wide;
    logic [X_W-1:0]          s2_x;
    logic                    s2_neg;

    srmd_frame u_frame (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .s1_valid   (s1_valid),
        .s2_ready   (s2_ready),
        .s1_data    (s1_data)
    );

    srmd_decode #(
        .FRAC_BITS (FRAC_BITS)
    ) u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .s2_ready (s2_ready),
        .s1_data  (s1_data),
        .s2_valid (s2_valid),
        .s3_ready (s3_ready),
        .s2_meta  (s2_meta),
        .s2_wide  (s2_wide),
        .s2_x     (s2_x),
        .s2_neg   (s2_neg)
    );

    srmd_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .s2_valid     (s2_valid),
        .s3_ready     (s3_ready),
        .s2_meta      (s2_meta),
        .s2_wide      (s2_wide),
        .s2_x         (s2_x),
        .s2_neg       (s2_neg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

`ifndef ASSERT_OFF
    a_fail_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.status != ST_OK |-> result_data.value == '0)
        else $error("failed reply carries a non-zero value");

    a_ok_clears_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.status == ST_OK |-> !result_data.error_flag)
        else $error("good reply left the error flag set");

    a_zero_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.status == ST_ZERO |-> result_data.error_flag)
        else $error("zero value reply did not set the error flag");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> result_valid && result_stall)
        else $error("input stalled while the pipeline had room");
`endif

endmodule
